>>> rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, codes and defaults for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Parameter defaults
  localparam int unsigned CapacityDef   = 16;
  localparam int unsigned ValueWidthDef = 32;

  // Fixed stream field widths
  localparam int unsigned OpW       = 2;
  localparam int unsigned InValueW  = 32;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned PositionW = 4;
  localparam int unsigned CountW    = 5;
  localparam int unsigned HeadW     = 32;

  localparam int unsigned InTdataW  = 40;  // 34 bits used
  localparam int unsigned OutTdataW = 48;  // 44 bits used

  // Operation codes (code 3 behaves as find)
  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_REMOVE = 2'd1;
  localparam logic [OpW-1:0] OP_FIND   = 2'd2;

  // Status codes
  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic               empty_res;
    logic [HeadW-1:0]   head_value;
    logic [CountW-1:0]  count;
    logic [PositionW-1:0] position;
    logic [StatusW-1:0] status;
  } result_t;

endpackage

>>> rtl/spq_mem.sv
// ----------------------------------------------------------------------------
// spq_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spq_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: scans and shifts the entry store one entry at a time.
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
#(
  parameter int unsigned Capacity   = CapacityDef,
  parameter int unsigned ValueWidth = ValueWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [OpW-1:0]              in_op_i,
  input  logic [InValueW-1:0]         in_value_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output result_t                     res_o,
  output logic                        mem_we_o,
  output logic [$clog2(Capacity)-1:0] mem_waddr_o,
  output logic [ValueWidth-1:0]       mem_wdata_o,
  output logic                        mem_re_o,
  output logic [$clog2(Capacity)-1:0] mem_raddr_o,
  input  logic [ValueWidth-1:0]       mem_rdata_i
);

  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_RD   = 3'd1;
  localparam logic [2:0] S_INS_CHK  = 3'd2;
  localparam logic [2:0] S_SCAN_RD  = 3'd3;
  localparam logic [2:0] S_SCAN_CHK = 3'd4;
  localparam logic [2:0] S_SHIFT_RD = 3'd5;
  localparam logic [2:0] S_SHIFT_WR = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]                   state_q, state_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [CntW-1:0]              slot_q, slot_d;
  logic [OpW-1:0]               op_q, op_d;
  logic signed [ValueWidth-1:0] val_q, val_d;
  logic signed [ValueWidth-1:0] head_q, head_d;
  logic [StatusW-1:0]           status_q, status_d;
  logic [IdxW-1:0]              pos_q, pos_d;

  logic [ValueWidth+InValueW-1:0] vin_ext;
  logic signed [ValueWidth-1:0]   vin;
  logic signed [ValueWidth-1:0]   rdata;
  logic [CntW-1:0]                slot_inc, slot_dec;
  logic [IdxW+PositionW-1:0]      pos_ext;
  logic [CntW+CountW-1:0]         cnt_ext;
  logic [ValueWidth+HeadW-1:0]    head_ext;

  // Input value sign-extended or truncated to the stored width
  assign vin_ext  = {{ValueWidth{in_value_i[InValueW-1]}}, in_value_i};
  assign vin      = vin_ext[ValueWidth-1:0];
  assign rdata    = mem_rdata_i;
  assign slot_inc = slot_q + 1'b1;
  assign slot_dec = slot_q - 1'b1;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    slot_d      = slot_q;
    op_d        = op_q;
    val_d       = val_q;
    status_d    = status_q;
    pos_d       = pos_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = slot_q[IdxW-1:0];
    mem_wdata_o = val_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = slot_q[IdxW-1:0];
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d     = in_op_i;
          val_d    = vin;
          status_d = ST_OK;
          pos_d    = '0;
          if (in_op_i == OP_INSERT) begin
            if (cnt_q == CntW'(Capacity)) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              slot_d  = cnt_q;
              state_d = S_INS_RD;
            end
          end else begin
            slot_d  = '0;
            state_d = S_SCAN_RD;
          end
        end
      end

      // Walk from the tail toward the head, moving smaller entries down
      S_INS_RD: begin
        if (slot_q == '0) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = '0;
          pos_d       = '0;
          cnt_d       = cnt_q + 1'b1;
          state_d     = S_DONE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = slot_dec[IdxW-1:0];
          state_d     = S_INS_CHK;
        end
      end

      S_INS_CHK: begin
        mem_we_o = 1'b1;
        if (rdata < val_q) begin
          mem_wdata_o = rdata;
          slot_d      = slot_dec;
          state_d     = S_INS_RD;
        end else begin
          pos_d   = slot_q[IdxW-1:0];
          cnt_d   = cnt_q + 1'b1;
          state_d = S_DONE;
        end
      end

      // Search from the head for the first equal entry
      S_SCAN_RD: begin
        if (slot_q == cnt_q) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end else begin
          mem_re_o = 1'b1;
          state_d  = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        if (rdata == val_q) begin
          pos_d   = slot_q[IdxW-1:0];
          state_d = (op_q == OP_REMOVE) ? S_SHIFT_RD : S_DONE;
        end else begin
          slot_d  = slot_inc;
          state_d = S_SCAN_RD;
        end
      end

      // Close the gap left by a removed entry
      S_SHIFT_RD: begin
        if (slot_inc == cnt_q) begin
          cnt_d   = cnt_q - 1'b1;
          state_d = S_DONE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = slot_inc[IdxW-1:0];
          state_d     = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = rdata;
        slot_d      = slot_inc;
        state_d     = S_SHIFT_RD;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Head entry is mirrored in a register on every write to slot 0
  always_comb begin
    head_d = head_q;
    if (mem_we_o && (mem_waddr_o == '0)) begin
      head_d = mem_wdata_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    op_q     <= op_d;
    val_q    <= val_d;
    head_q   <= head_d;
    status_q <= status_d;
    pos_q    <= pos_d;
  end

  assign pos_ext  = {{PositionW{1'b0}}, pos_q};
  assign cnt_ext  = {{CountW{1'b0}}, cnt_q};
  assign head_ext = {{HeadW{head_q[ValueWidth-1]}}, head_q};

  always_comb begin
    res_o.status     = status_q;
    res_o.position   = (status_q == ST_OK) ? pos_ext[PositionW-1:0] : '0;
    res_o.count      = cnt_ext[CountW-1:0];
    res_o.empty_res  = (cnt_q == '0);
    res_o.head_value = (cnt_q == '0) ? '0 : head_ext[HeadW-1:0];
  end

endmodule

>>> rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Descending sorted list of signed values with insert, remove and find.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_*: one transaction per command (op, value).
//   Master channel m_axis_*: exactly one result transaction per command,
//   in command order, with status, position, count, head value and empty.
//   Commands are processed one at a time; a new command is accepted only
//   after the previous result has left the sequencer. An insert walks
//   from the tail toward the head past the smaller entries; find and
//   remove scan from the head to the first equal entry, and remove then
//   shifts the entries behind it up; a miss scans every entry; a full
//   insert does no walk. The walk over the entry memory is sequential:
//   each entry visited costs one read step and one compare or write step.
//   Reset clears the entry count and control; memory contents are not
//   cleared, only entries below the count are ever read.
//   A finished result sits in the output register while the next command
//   is accepted; if the receiver stalls, the sequencer holds its next
//   result until the register frees up, then returns to accept.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY    = CapacityDef,
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // [1:0] op, [33:2] value
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata    // [1:0] status, [5:2] position,
                                               // [10:6] count, [42:11] head_value,
                                               // [43] empty_res
);

  localparam int unsigned IdxW = $clog2(CAPACITY);

  logic                   res_valid;
  logic                   res_ready;
  result_t                res;
  logic                   mem_we;
  logic [IdxW-1:0]        mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic                   mem_re;
  logic [IdxW-1:0]        mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;

  logic                   m_valid_q, m_valid_d;
  logic [OutTdataW-1:0]   m_data_q, m_data_d;

  spq_ctrl #(
    .Capacity   (CAPACITY),
    .ValueWidth (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tdata[OpW-1:0]),
    .in_value_i  (s_axis_tdata[OpW+InValueW-1:OpW]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  spq_mem #(
    .Depth (CAPACITY),
    .Width (VALUE_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: free when empty or being drained this cycle
  assign res_ready = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (res_valid && res_ready) begin
      m_valid_d = 1'b1;
      m_data_d  = {4'b0000, res};
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
